// ----- design/tce_pkg.sv -----
// Shared types and constants for the TTL cache with earliest-expiry eviction.
`timescale 1ns / 1ps
`default_nettype none
package tce_pkg;

    localparam int KEY_W = 64;
    localparam int TTL_W = 31;
    localparam int NOW_W = 32;
    localparam int EXP_W = 33;
    localparam int HND_W = 16;
    localparam int AGE_W = 8;
    localparam int LIM_W = 4;

    localparam int CAPACITY_DEF = 8;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 4'd5;

    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 136;

    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // One cached record
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [EXP_W-1:0] expiry;
        logic [HND_W-1:0] handle;
        logic [AGE_W-1:0] age;
    } t_entry;

    // First entry whose key matched
    typedef struct packed {
        logic             found;
        logic [EXP_W-1:0] expiry;
        logic [HND_W-1:0] handle;
    } t_match;

    // Earliest-expiring entry seen so far
    typedef struct packed {
        logic   valid;
        t_entry ent;
    } t_best;

endpackage
`default_nettype wire

// ----- design/tce_cell.sv -----
// One cache slot: holds an entry and updates the scan record passing through it.
`timescale 1ns / 1ps
`default_nettype none
module tce_cell #(
    parameter int CAPACITY = tce_pkg::CAPACITY_DEF,
    parameter int IDX      = 0
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // write port
    input  wire                               i_wr,
    input  wire                               i_clr,
    input  tce_pkg::t_entry                   i_wr_ent,
    // operands of the current item
    input  wire [tce_pkg::KEY_W-1:0]          i_key,
    input  wire [tce_pkg::AGE_W-1:0]          i_counter,
    // scan record in
    input  wire                               i_step,
    input  tce_pkg::t_match                   i_match,
    input  wire [$clog2(CAPACITY)-1:0]        i_mslot,
    input  tce_pkg::t_best                    i_best,
    input  wire [$clog2(CAPACITY)-1:0]        i_bslot,
    input  wire [$clog2(CAPACITY+1)-1:0]      i_cnt,
    input  wire                               i_free,
    input  wire [$clog2(CAPACITY)-1:0]        i_fslot,
    // scan record out
    output logic                              o_step,
    output tce_pkg::t_match                   o_match,
    output logic [$clog2(CAPACITY)-1:0]       o_mslot,
    output tce_pkg::t_best                    o_best,
    output logic [$clog2(CAPACITY)-1:0]       o_bslot,
    output logic [$clog2(CAPACITY+1)-1:0]     o_cnt,
    output logic                              o_free,
    output logic [$clog2(CAPACITY)-1:0]       o_fslot
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] MY_SLOT = IW'(IDX);

    logic                  r_valid;
    tce_pkg::t_entry       r_ent;

    logic                  w_hit;
    logic                  w_take;
    logic [tce_pkg::AGE_W-1:0] w_dist_me;
    logic [tce_pkg::AGE_W-1:0] w_dist_best;

    tce_pkg::t_match       n_match;
    logic [IW-1:0]         n_mslot;
    tce_pkg::t_best        n_best;
    logic [IW-1:0]         n_bslot;
    logic                  n_free;
    logic [IW-1:0]         n_fslot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr) begin
            r_valid <= 1'b1;
        end else if (i_clr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_ent <= i_wr_ent;
        end
    end

    assign w_hit       = r_valid && (r_ent.key == i_key);
    assign w_dist_me   = i_counter - r_ent.age;
    assign w_dist_best = i_counter - i_best.ent.age;
    // older insertion wins a tie on expiry; equal age keeps the lower slot
    assign w_take = r_valid && (!i_best.valid || (r_ent.expiry < i_best.ent.expiry) ||
                    ((r_ent.expiry == i_best.ent.expiry) && (w_dist_me > w_dist_best)));

    always_comb begin
        n_match = i_match;
        n_mslot = i_mslot;
        if (!i_match.found && w_hit) begin
            n_match.found  = 1'b1;
            n_match.expiry = r_ent.expiry;
            n_match.handle = r_ent.handle;
            n_mslot        = MY_SLOT;
        end
        n_best  = i_best;
        n_bslot = i_bslot;
        if (w_take) begin
            n_best.valid = 1'b1;
            n_best.ent   = r_ent;
            n_bslot      = MY_SLOT;
        end
        n_free  = i_free;
        n_fslot = i_fslot;
        if (!i_free && !r_valid) begin
            n_free  = 1'b1;
            n_fslot = MY_SLOT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_step <= 1'b0;
        end else begin
            o_step <= i_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            o_match <= n_match;
            o_mslot <= n_mslot;
            o_best  <= n_best;
            o_bslot <= n_bslot;
            o_cnt   <= i_cnt + CW'(r_valid);
            o_free  <= n_free;
            o_fslot <= n_fslot;
        end
    end

endmodule
`default_nettype wire

// ----- design/ttl_cache_min_expiry_evict_core.sv -----
// Top level of the TTL cache: input/output stream control, decision and write back.
//
// Usage:
//   Slave stream carries one request per beat: s_axis_tuser is the opcode
//   (0 store, 1 lookup), s_axis_tdata holds key, ttl, now and answer handle.
//   Master stream returns exactly one result beat per request: hit flag and
//   handle with remaining TTL for lookups, stored/evicted flags and the
//   evicted record for stores; fields that do not apply read as zero.
//   i_cfg_we/i_cfg_wdata set the entry limit (reset value 5); write it only
//   while no request is in flight.
//   Each request walks a scan record down a chain of CAPACITY slot cells,
//   one cell per cycle; once the record reaches the tail, the result is
//   decided and written back as soon as the output register is free. A new
//   request is accepted the cycle after the result is loaded, so the block
//   never scans two requests at once.
//   Reset (synchronous, active low) empties all slots, zeroes the insertion
//   counter and restores the entry limit. When the master side stalls, the
//   finished result waits in the output register while the next request is
//   taken and scanned; its decision holds until that register frees up.
`timescale 1ns / 1ps
`default_nettype none
module ttl_cache_min_expiry_evict_core #(
    parameter int CAPACITY = tce_pkg::CAPACITY_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [tce_pkg::LIM_W-1:0]           i_cfg_wdata,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // [63:0] key, [94:64] ttl, [126:95] now, [142:127] answer_handle, [143] zero
    input  wire [tce_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] opcode
    input  wire                                s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [0] hit, [16:1] hit_handle, [48:17] remaining_ttl, [49] stored,
    // [50] evicted, [114:51] evicted_key, [130:115] evicted_handle, [135:131] zero
    output logic [tce_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > tce_pkg::LIM_W) ? CW : tce_pkg::LIM_W;
    localparam int PAD_W = tce_pkg::OUT_TDATA_W - 131;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic                          r_go;
    logic [tce_pkg::LIM_W-1:0]     r_limit;
    logic [tce_pkg::AGE_W-1:0]     r_counter;

    logic                          r_op;
    logic [tce_pkg::KEY_W-1:0]     r_key;
    logic [tce_pkg::TTL_W-1:0]     r_ttl;
    logic [tce_pkg::NOW_W-1:0]     r_now;
    logic [tce_pkg::HND_W-1:0]     r_hnd;

    logic                          r_out_valid;
    logic [tce_pkg::OUT_TDATA_W-1:0] r_out_data;

    // scan chain
    logic                          w_step  [0:CAPACITY];
    tce_pkg::t_match               w_match [0:CAPACITY];
    logic [IW-1:0]                 w_mslot [0:CAPACITY];
    tce_pkg::t_best                w_best  [0:CAPACITY];
    logic [IW-1:0]                 w_bslot [0:CAPACITY];
    logic [CW-1:0]                 w_cnt   [0:CAPACITY];
    logic                          w_free  [0:CAPACITY];
    logic [IW-1:0]                 w_fslot [0:CAPACITY];

    logic [CAPACITY-1:0]           w_wr_vec;
    logic [CAPACITY-1:0]           w_clr_vec;
    tce_pkg::t_entry               w_wr_ent;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_fire;
    logic                          w_done;
    logic [tce_pkg::EXP_W-1:0]     w_exp_new;
    logic [tce_pkg::EXP_W-1:0]     w_now_x;
    logic [tce_pkg::EXP_W-1:0]     w_rem_full;
    logic                          w_full;
    logic                          w_evict;
    logic                          w_do_wr;
    logic                          w_do_clr;
    logic [IW-1:0]                 w_wr_slot;

    logic                          n_hit;
    logic [tce_pkg::HND_W-1:0]     n_hit_handle;
    logic [tce_pkg::NOW_W-1:0]     n_rem;
    logic                          n_stored;
    logic                          n_evicted;
    logic [tce_pkg::KEY_W-1:0]     n_ev_key;
    logic [tce_pkg::HND_W-1:0]     n_ev_handle;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_done        = w_step[CAPACITY];
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fire        = (r_state == S_WAIT) && w_out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_done) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_go      <= 1'b0;
            r_limit   <= tce_pkg::LIMIT_RESET;
            r_counter <= '0;
        end else begin
            r_state <= n_state;
            r_go    <= w_accept;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (w_fire && w_do_wr) begin
                r_counter <= r_counter + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= s_axis_tuser;
            r_key <= s_axis_tdata[63:0];
            r_ttl <= s_axis_tdata[94:64];
            r_now <= s_axis_tdata[126:95];
            r_hnd <= s_axis_tdata[142:127];
        end
    end

    // head of the chain: empty scan record
    assign w_step[0]  = r_go;
    assign w_match[0] = '0;
    assign w_mslot[0] = '0;
    assign w_best[0]  = '0;
    assign w_bslot[0] = '0;
    assign w_cnt[0]   = '0;
    assign w_free[0]  = 1'b0;
    assign w_fslot[0] = '0;

    assign w_wr_ent.key    = r_key;
    assign w_wr_ent.expiry = w_exp_new;
    assign w_wr_ent.handle = r_hnd;
    assign w_wr_ent.age    = r_counter;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign w_wr_vec[g]  = w_fire && w_do_wr && (w_wr_slot == IW'(g));
            assign w_clr_vec[g] = w_fire && w_do_clr && (w_bslot[CAPACITY] == IW'(g));

            tce_cell #(
                .CAPACITY (CAPACITY),
                .IDX      (g)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_wr      (w_wr_vec[g]),
                .i_clr     (w_clr_vec[g]),
                .i_wr_ent  (w_wr_ent),
                .i_key     (r_key),
                .i_counter (r_counter),
                .i_step    (w_step[g]),
                .i_match   (w_match[g]),
                .i_mslot   (w_mslot[g]),
                .i_best    (w_best[g]),
                .i_bslot   (w_bslot[g]),
                .i_cnt     (w_cnt[g]),
                .i_free    (w_free[g]),
                .i_fslot   (w_fslot[g]),
                .o_step    (w_step[g+1]),
                .o_match   (w_match[g+1]),
                .o_mslot   (w_mslot[g+1]),
                .o_best    (w_best[g+1]),
                .o_bslot   (w_bslot[g+1]),
                .o_cnt     (w_cnt[g+1]),
                .o_free    (w_free[g+1]),
                .o_fslot   (w_fslot[g+1])
            );
        end
    endgenerate

    // decision on the finished scan record
    assign w_now_x    = {1'b0, r_now};
    assign w_exp_new  = w_now_x + {2'b00, r_ttl};
    assign w_rem_full = w_match[CAPACITY].expiry - w_now_x;
    // effective limit is min(entry_limit, CAPACITY)
    assign w_full  = (LW'(w_cnt[CAPACITY]) >= LW'(r_limit)) ||
                     (w_cnt[CAPACITY] == CW'(CAPACITY));
    assign w_evict = w_best[CAPACITY].valid &&
                     (w_full || (w_now_x > w_best[CAPACITY].ent.expiry));

    always_comb begin
        n_hit        = 1'b0;
        n_hit_handle = '0;
        n_rem        = '0;
        n_stored     = 1'b0;
        n_evicted    = 1'b0;
        n_ev_key     = '0;
        n_ev_handle  = '0;
        w_do_wr      = 1'b0;
        w_do_clr     = 1'b0;
        w_wr_slot    = w_fslot[CAPACITY];
        if (r_op == tce_pkg::OP_LOOKUP) begin
            if (w_match[CAPACITY].found && (w_now_x <= w_match[CAPACITY].expiry)) begin
                n_hit        = 1'b1;
                n_hit_handle = w_match[CAPACITY].handle;
                n_rem        = w_rem_full[tce_pkg::EXP_W-1] ? '1 :
                               w_rem_full[tce_pkg::NOW_W-1:0];
            end
        end else if (w_match[CAPACITY].found) begin
            // same key: replace in place unless the held record lives longer
            if (!(w_match[CAPACITY].expiry > w_exp_new)) begin
                n_stored    = 1'b1;
                n_evicted   = 1'b1;
                n_ev_key    = r_key;
                n_ev_handle = w_match[CAPACITY].handle;
                w_do_wr     = 1'b1;
                w_wr_slot   = w_mslot[CAPACITY];
            end
        end else begin
            if (w_evict) begin
                n_evicted   = 1'b1;
                n_ev_key    = w_best[CAPACITY].ent.key;
                n_ev_handle = w_best[CAPACITY].ent.handle;
                w_do_clr    = 1'b1;
            end
            // lowest free slot after the eviction
            if (w_free[CAPACITY]) begin
                w_do_wr  = 1'b1;
                n_stored = 1'b1;
                if (w_evict && (w_bslot[CAPACITY] < w_fslot[CAPACITY])) begin
                    w_wr_slot = w_bslot[CAPACITY];
                end
            end else if (w_evict) begin
                w_do_wr   = 1'b1;
                n_stored  = 1'b1;
                w_wr_slot = w_bslot[CAPACITY];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {{PAD_W{1'b0}}, n_ev_handle, n_ev_key, n_evicted, n_stored,
                           n_rem, n_hit_handle, n_hit};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // the scan pulse only reaches the tail while the block is scanning
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_SCAN))
        else $error("scan record arrived outside the scan phase");

    // one request in flight: never a scan pulse at the head and the tail at once
    a_single_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_step[CAPACITY], r_go}) <= 1)
        else $error("overlapping scan pulses");

    // a write back never targets more than one slot
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_wr_vec))
        else $error("multiple slots written");

    // after the result is loaded the slave side opens again
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (s_axis_tready && m_axis_tvalid))
        else $error("block did not return to idle after a result");
`endif

endmodule
`default_nettype wire

// ----- sim/ttl_cache_min_expiry_evict_core_tb.sv -----
// Self-checking testbench for the TTL cache core: directed table plus randomized phases.
`timescale 1ns / 1ps
module ttl_cache_min_expiry_evict_core_tb;
    import tce_pkg::*;

    localparam int CAP       = CAPACITY_DEF;
    localparam int SCAN_LAT  = CAP + 3;
    localparam int STALL_MAX = 2000;
    localparam int N_PHASES  = 10;
    localparam int PHASE_LEN = 100;
    localparam logic [KEY_W-1:0] KEY_ONES = {KEY_W{1'b1}};

    localparam logic [LIM_W-1:0] LIMIT_PLAN [N_PHASES] =
        '{4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd10, 4'd2, 4'd7, 4'd4, 4'd5};
    // last phase runs with no idling on either side
    localparam bit IDLE_PLAN [N_PHASES] = '{1, 1, 0, 1, 1, 0, 1, 1, 1, 0};

    typedef struct packed {
        logic             hit;
        logic [HND_W-1:0] hit_handle;
        logic [NOW_W-1:0] remaining_ttl;
        logic             stored;
        logic             evicted;
        logic [KEY_W-1:0] evicted_key;
        logic [HND_W-1:0] evicted_handle;
    } outcome_t;

    localparam outcome_t NO_RESULT = '0;

    typedef struct {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [TTL_W-1:0] ttl;
        logic [NOW_W-1:0] now;
        logic [HND_W-1:0] handle;
        bit               golden;
        outcome_t         want;
    } request_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [LIM_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    wire                    s_axis_tready;
    // [63:0] key, [94:64] ttl, [126:95] now, [142:127] answer_handle, [143] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [0] opcode
    logic                   s_axis_tuser = 1'b0;
    wire                    m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] hit, [16:1] hit_handle, [48:17] remaining_ttl, [49] stored,
    // [50] evicted, [114:51] evicted_key, [130:115] evicted_handle, [135:131] zero
    wire [OUT_TDATA_W-1:0]  m_axis_tdata;

    ttl_cache_min_expiry_evict_core #(
        .CAPACITY(CAP)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow copy of the cache contents
    logic             held        [CAP];
    logic [KEY_W-1:0] held_key    [CAP];
    logic [EXP_W-1:0] held_expiry [CAP];
    logic [HND_W-1:0] held_handle [CAP];
    logic [AGE_W-1:0] held_stamp  [CAP];
    logic [AGE_W-1:0] stamp_next;
    logic [LIM_W-1:0] limit_now;

    outcome_t pending_outcomes [$];
    request_t plan [$];
    outcome_t seen_want;

    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;
    int rx_hold = 0;
    int mismatches = 0;
    int beats_seen = 0;
    int requests_sent = 0;
    int hits_seen = 0;
    int evictions_seen = 0;
    int settings_used = 0;
    int quiet_cycles = 0;

    function automatic void fill_slot(int s, logic [KEY_W-1:0] key, logic [EXP_W-1:0] expiry,
                                      logic [HND_W-1:0] hnd);
        held[s]        = 1'b1;
        held_key[s]    = key;
        held_expiry[s] = expiry;
        held_handle[s] = hnd;
        held_stamp[s]  = stamp_next;
        stamp_next     = stamp_next + 1'b1;
    endfunction

    function automatic outcome_t cache_outcome(logic op, logic [KEY_W-1:0] key,
                                               logic [TTL_W-1:0] ttl, logic [NOW_W-1:0] now,
                                               logic [HND_W-1:0] hnd);
        outcome_t         r;
        int               i, slot, first, count, lim;
        logic [EXP_W-1:0] expiry, rem;
        logic [AGE_W-1:0] dist_i, dist_f;
        r     = '0;
        slot  = -1;
        first = -1;
        count = 0;
        for (i = CAP - 1; i >= 0; i--)
            if (held[i] && held_key[i] == key)
                slot = i;

        if (op == OP_LOOKUP) begin
            // live up to and including the expiry second
            if (slot >= 0 && {1'b0, now} <= held_expiry[slot]) begin
                rem             = held_expiry[slot] - {1'b0, now};
                r.hit           = 1'b1;
                r.hit_handle    = held_handle[slot];
                r.remaining_ttl = rem[EXP_W-1] ? {NOW_W{1'b1}} : rem[NOW_W-1:0];
            end
            return r;
        end

        expiry = {1'b0, now} + {2'b00, ttl};
        if (slot >= 0) begin
            if (held_expiry[slot] > expiry)
                return r;
            r.stored         = 1'b1;
            r.evicted        = 1'b1;
            r.evicted_key    = held_key[slot];
            r.evicted_handle = held_handle[slot];
            fill_slot(slot, key, expiry, hnd);
            return r;
        end

        // earliest expiry, ties to the oldest stamp, then the lowest slot
        for (i = 0; i < CAP; i++) begin
            if (held[i]) begin
                count++;
                if (first < 0 || held_expiry[i] < held_expiry[first]) begin
                    first = i;
                end else if (held_expiry[i] == held_expiry[first]) begin
                    dist_i = stamp_next - held_stamp[i];
                    dist_f = stamp_next - held_stamp[first];
                    if (dist_i > dist_f)
                        first = i;
                end
            end
        end
        lim = (limit_now > CAP) ? CAP : limit_now;
        if (first >= 0 && (count >= lim || {1'b0, now} > held_expiry[first])) begin
            r.evicted        = 1'b1;
            r.evicted_key    = held_key[first];
            r.evicted_handle = held_handle[first];
            held[first]      = 1'b0;
        end
        slot = -1;
        for (i = CAP - 1; i >= 0; i--)
            if (!held[i])
                slot = i;
        if (slot >= 0) begin
            fill_slot(slot, key, expiry, hnd);
            r.stored = 1'b1;
        end
        return r;
    endfunction

    function automatic outcome_t hit_result(logic [HND_W-1:0] hnd, logic [NOW_W-1:0] rem);
        outcome_t r;
        r               = '0;
        r.hit           = 1'b1;
        r.hit_handle    = hnd;
        r.remaining_ttl = rem;
        return r;
    endfunction

    function automatic outcome_t store_result(logic ev, logic [KEY_W-1:0] key,
                                              logic [HND_W-1:0] hnd);
        outcome_t r;
        r                = '0;
        r.stored         = 1'b1;
        r.evicted        = ev;
        r.evicted_key    = key;
        r.evicted_handle = hnd;
        return r;
    endfunction

    function automatic request_t row(logic op, logic [KEY_W-1:0] key, logic [TTL_W-1:0] ttl,
                                     logic [NOW_W-1:0] now, logic [HND_W-1:0] hnd,
                                     bit golden, outcome_t want);
        request_t rq;
        rq.op     = op;
        rq.key    = key;
        rq.ttl    = ttl;
        rq.now    = now;
        rq.handle = hnd;
        rq.golden = golden;
        rq.want   = want;
        return rq;
    endfunction

    task automatic log_mismatch(string field, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
        $display("[%0t] beat %0d %s: got 0x%0h, expected 0x%0h",
                 $time, beats_seen, field, got, want);
        mismatches++;
    endtask

    task automatic send_request(request_t rq);
        outcome_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, rq.handle, rq.now, rq.ttl, rq.key};
        s_axis_tuser  <= rq.op;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        r = cache_outcome(rq.op, rq.key, rq.ttl, rq.now, rq.handle);
        pending_outcomes.push_back(rq.golden ? rq.want : r);
        requests_sent++;
        if (tx_idle && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // limit changes only once the pipe has drained
    task automatic set_limit(logic [LIM_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SCAN_LAT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        limit_now   = v;
        settings_used++;
    endtask

    task automatic run_phase(int n_items, logic [LIM_W-1:0] lim, bit idle);
        request_t         rq;
        logic [KEY_W-1:0] pool [10];
        logic [NOW_W-1:0] clock_s;
        int               i, pick;
        set_limit(lim);
        tx_idle = idle;
        rx_idle = idle;
        for (i = 0; i < 10; i++)
            pool[i] = {$urandom, $urandom};
        clock_s = $urandom;
        for (i = 0; i < n_items; i++) begin
            clock_s = clock_s + $urandom_range(0, 6);
            // occasional clock step back
            if ($urandom_range(0, 29) == 0)
                clock_s = clock_s - $urandom_range(1, 60);
            rq.op  = ($urandom_range(0, 99) < 55) ? OP_STORE : OP_LOOKUP;
            rq.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                 : pool[$urandom_range(0, 9)];
            pick = $urandom_range(0, 9);
            case (pick)
                0: rq.ttl = TTL_W'($urandom);
                1: rq.ttl = {TTL_W{1'b1}};
                2: rq.ttl = '0;
                default: rq.ttl = TTL_W'($urandom_range(0, 40));
            endcase
            rq.now    = clock_s;
            rq.handle = HND_W'($urandom);
            rq.golden = 1'b0;
            rq.want   = NO_RESULT;
            send_request(rq);
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 7) == 0) begin
            rx_hold       <= $urandom_range(0, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_seen++;
            if (pending_outcomes.size() == 0) begin
                log_mismatch("result with nothing pending", m_axis_tdata[63:0], '0);
            end else begin
                seen_want = pending_outcomes.pop_front();
                if (m_axis_tdata[0] !== seen_want.hit)
                    log_mismatch("hit", m_axis_tdata[0], seen_want.hit);
                if (m_axis_tdata[16:1] !== seen_want.hit_handle)
                    log_mismatch("hit_handle", m_axis_tdata[16:1], seen_want.hit_handle);
                if (m_axis_tdata[48:17] !== seen_want.remaining_ttl)
                    log_mismatch("remaining_ttl", m_axis_tdata[48:17], seen_want.remaining_ttl);
                if (m_axis_tdata[49] !== seen_want.stored)
                    log_mismatch("stored", m_axis_tdata[49], seen_want.stored);
                if (m_axis_tdata[50] !== seen_want.evicted)
                    log_mismatch("evicted", m_axis_tdata[50], seen_want.evicted);
                if (m_axis_tdata[114:51] !== seen_want.evicted_key)
                    log_mismatch("evicted_key", m_axis_tdata[114:51], seen_want.evicted_key);
                if (m_axis_tdata[130:115] !== seen_want.evicted_handle)
                    log_mismatch("evicted_handle", m_axis_tdata[130:115],
                                 seen_want.evicted_handle);
                if (m_axis_tdata[135:131] !== 5'd0)
                    log_mismatch("pad bits", m_axis_tdata[135:131], '0);
                if (seen_want.hit)
                    hits_seen++;
                if (seen_want.evicted)
                    evictions_seen++;
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        while (quiet_cycles < STALL_MAX) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 STALL_MAX, pending_outcomes.size());
        $display("[ttl_cache_min_expiry_evict_core] ERROR");
        $finish;
    end

    initial begin
        int i;
        for (i = 0; i < CAP; i++)
            held[i] = 1'b0;
        stamp_next = '0;
        limit_now  = LIMIT_RESET;

        // lookup miss on empty cache, live-at-expiry edge, saturation, duplicate rules,
        // expired-entry eviction, limit eviction and oldest-stamp tie break
        plan.push_back(row(OP_LOOKUP, 64'd0, 31'd0, 32'd0, 16'd0, 1, NO_RESULT));
        plan.push_back(row(OP_STORE, 64'd0, 31'd0, 32'd0, 16'd0, 1,
                           store_result(1'b0, 64'd0, 16'd0)));
        plan.push_back(row(OP_LOOKUP, 64'd0, 31'd0, 32'd0, 16'd0, 1,
                           hit_result(16'd0, 32'd0)));
        plan.push_back(row(OP_LOOKUP, 64'd0, 31'd0, 32'd1, 16'd0, 1, NO_RESULT));
        // key 0 has expired by now, so it is pushed out first
        plan.push_back(row(OP_STORE, KEY_ONES, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1,
                           store_result(1'b1, 64'd0, 16'd0)));
        plan.push_back(row(OP_LOOKUP, KEY_ONES, 31'd0, 32'd0, 16'd0, 1,
                           hit_result(16'hFFFF, 32'hFFFF_FFFF)));
        plan.push_back(row(OP_LOOKUP, KEY_ONES, 31'd0, 32'hFFFF_FFFF, 16'd0, 1,
                           hit_result(16'hFFFF, 32'h7FFF_FFFF)));
        plan.push_back(row(OP_STORE, KEY_ONES, 31'd0, 32'd0, 16'h1234, 1, NO_RESULT));
        plan.push_back(row(OP_STORE, KEY_ONES, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h5555, 1,
                           store_result(1'b1, KEY_ONES, 16'hFFFF)));
        plan.push_back(row(OP_STORE, 64'd2, 31'd10, 32'd5, 16'd2, 1,
                           store_result(1'b0, 64'd0, 16'd0)));
        for (i = 3; i <= 8; i++)
            plan.push_back(row(OP_STORE, KEY_W'(i), 31'd100, 32'd5, HND_W'(i), 0,
                               NO_RESULT));
        plan.push_back(row(OP_LOOKUP, 64'd3, 31'd0, 32'd50, 16'd0, 0, NO_RESULT));
        plan.push_back(row(OP_LOOKUP, 64'd5, 31'd0, 32'd105, 16'd0, 0, NO_RESULT));
        plan.push_back(row(OP_LOOKUP, 64'd5, 31'd0, 32'd106, 16'd0, 0, NO_RESULT));
        plan.push_back(row(OP_LOOKUP, 64'hAAAA_5555_AAAA_5555, 31'd0, 32'd7, 16'd0, 0,
                           NO_RESULT));
        plan.push_back(row(OP_STORE, 64'd5, 31'd0, 32'd106, 16'd9, 0, NO_RESULT));
        plan.push_back(row(OP_LOOKUP, 64'd5, 31'd0, 32'd106, 16'd0, 0, NO_RESULT));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        foreach (plan[j])
            send_request(plan[j]);

        for (i = 0; i < N_PHASES; i++)
            run_phase(PHASE_LEN, LIMIT_PLAN[i], IDLE_PLAN[i]);

        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SCAN_LAT + 5) @(posedge i_clk);

        $display("%0d requests over %0d limit settings, %0d result beats checked",
                 requests_sent, settings_used, beats_seen);
        $display("%0d lookup hits, %0d replacements or evictions, %0d mismatches",
                 hits_seen, evictions_seen, mismatches);
        if (mismatches == 0)
            $display("[ttl_cache_min_expiry_evict_core] OK");
        else
            $display("[ttl_cache_min_expiry_evict_core] ERROR");
        $finish;
    end

endmodule

// ----- ttl_cache_min_expiry_evict_core.f -----
design/tce_pkg.sv
design/tce_cell.sv
design/ttl_cache_min_expiry_evict_core.sv
sim/ttl_cache_min_expiry_evict_core_tb.sv
